// ===== src/hpoc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpoc_pkg
// Shared types and constants of the hold-to-power-off controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hpoc_pkg;

   localparam int CFG_TIME_WIDTH  = 16;
   localparam int CFG_COUNT_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int OPCODE_WIDTH    = 2;
   localparam int MODE_WIDTH      = 3;

   // timer and blink counter are as wide as the registers that load them
   localparam int TIMER_WIDTH = CFG_TIME_WIDTH;
   localparam int BLINK_WIDTH = CFG_COUNT_WIDTH;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_TICK    = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_BOOT    = 2'd3
   } opcode_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_IDLE     = 3'd0,
      MODE_HOLD     = 3'd1,
      MODE_COOLDOWN = 3'd2,
      MODE_BLINK    = 3'd3,
      MODE_WAKE     = 3'd4,
      MODE_OFF      = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_HOLD_TIME    = 2'd0,
      REG_LED_TIMEOUT  = 2'd1,
      REG_BLINK_TOTAL  = 2'd2,
      REG_BLINK_PERIOD = 2'd3
   } reg_index_type;

   localparam logic [CFG_TIME_WIDTH-1:0]  HOLD_TIME_RESET    = 16'd2000;
   localparam logic [CFG_TIME_WIDTH-1:0]  LED_TIMEOUT_RESET  = 16'd1000;
   localparam logic [CFG_COUNT_WIDTH-1:0] BLINK_TOTAL_RESET  = 8'd3;
   localparam logic [CFG_TIME_WIDTH-1:0]  BLINK_PERIOD_RESET = 16'd200;

   typedef struct packed {
      logic [CFG_TIME_WIDTH-1:0]  hold_time;
      logic [CFG_TIME_WIDTH-1:0]  led_timeout;
      logic [CFG_COUNT_WIDTH-1:0] blink_total;
      logic [CFG_TIME_WIDTH-1:0]  blink_period;
   } cfg_type;

   typedef struct packed {
      logic     led_level;
      logic     power_off;
      mode_type mode_code;
   } result_type;

endpackage

`default_nettype wire

// ===== src/hpoc_if.sv =====
// ----------------------------------------------------------------------------
// hpoc channel interfaces
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpoc_req_if import hpoc_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic                    switch_level;

   modport source (output valid, output opcode, output switch_level, input ready);
   modport sink   (input valid, input opcode, input switch_level, output ready);
endinterface

interface hpoc_rsp_if import hpoc_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic                  led_level;
   logic                  power_off;
   logic [MODE_WIDTH-1:0] mode_code;

   modport source (output valid, output led_level, output power_off, output mode_code,
                   input ready);
   modport sink   (input valid, input led_level, input power_off, input mode_code,
                   output ready);
endinterface

interface hpoc_csr_if import hpoc_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/hold_to_power_off_controller.sv =====
// ----------------------------------------------------------------------------
// hold_to_power_off_controller
// Power switch hold controller: hold timer, cooldown, LED blinks, power-off.
//
// req: one event word per handshake (opcode: tick, press, release, boot
//   check; switch_level read with boot check only).
// rsp: one result word per event: LED level, power-off request, mode code.
// csr: register writes (hold time, LED timeout, blink count, blink period),
//   always ready; write only while no event is in flight.
// Path: an event taken from req is held in the event register; when it advances,
//   its result word is loaded into the result register and is valid from then on.
// Throughput: one event per cycle while rsp is not stalled, set by the single
//   state update step between the event register and the result register.
// Reset clears mode to idle, timer, blink count, LED and both pipeline
//   valid flags, and loads the register defaults.
// While rsp is stalled the result word holds; one more event waits in the
//   event register, then req_bus.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hold_to_power_off_controller import hpoc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   hpoc_req_if.sink   req_bus,
   hpoc_rsp_if.source rsp_bus,
   hpoc_csr_if.sink   csr_bus
);

   cfg_type                 cfg;
   result_type              core_result;

   logic                    ev_valid_ff, ev_valid_in;
   logic [OPCODE_WIDTH-1:0] ev_opcode_ff;
   logic                    ev_level_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_word_ff;

   logic                    take_req;
   logic                    advance;

   assign advance  = ev_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign take_req = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !ev_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   assign ev_valid_in  = take_req || (ev_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);

   hpoc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   hpoc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .opcode       (ev_opcode_ff),
      .switch_level (ev_level_ff),
      .cfg          (cfg),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         ev_opcode_ff <= req_bus.opcode;
         ev_level_ff  <= req_bus.switch_level;
      end
      if (advance) begin
         rsp_word_ff <= core_result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.led_level = rsp_word_ff.led_level;
   assign rsp_bus.power_off = rsp_word_ff.power_off;
   assign rsp_bus.mode_code = rsp_word_ff.mode_code;

endmodule

`default_nettype wire

// ===== src/hpoc_csr.sv =====
// ----------------------------------------------------------------------------
// hpoc_csr
// Configuration registers, written one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module hpoc_csr import hpoc_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  wr_data,
   output      cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(wr_index))
            REG_HOLD_TIME:    cfg_in.hold_time    = wr_data[CFG_TIME_WIDTH-1:0];
            REG_LED_TIMEOUT:  cfg_in.led_timeout  = wr_data[CFG_TIME_WIDTH-1:0];
            REG_BLINK_TOTAL:  cfg_in.blink_total  = wr_data[CFG_COUNT_WIDTH-1:0];
            REG_BLINK_PERIOD: cfg_in.blink_period = wr_data[CFG_TIME_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time    <= HOLD_TIME_RESET;
         cfg_ff.led_timeout  <= LED_TIMEOUT_RESET;
         cfg_ff.blink_total  <= BLINK_TOTAL_RESET;
         cfg_ff.blink_period <= BLINK_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/hpoc_core.sv =====
// ----------------------------------------------------------------------------
// hpoc_core
// Mode state machine, hold/blink countdown and LED state; one event per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hpoc_core import hpoc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [OPCODE_WIDTH-1:0] opcode,
   input  wire logic                    switch_level,
   input  wire cfg_type                 cfg,
   output      result_type              result
);

   mode_type               mode_ff, mode_in;
   logic [TIMER_WIDTH-1:0] count_ff, count_in;
   logic [BLINK_WIDTH-1:0] blinks_ff, blinks_in;
   logic                   phase_ff, phase_in;
   logic                   pressed_ff, pressed_in;
   logic                   led_ff, led_in;

   logic                   timed;
   logic                   fire;
   logic [TIMER_WIDTH-1:0] half_period;

   assign timed = (mode_ff == MODE_HOLD) || (mode_ff == MODE_WAKE) ||
                  (mode_ff == MODE_COOLDOWN) || (mode_ff == MODE_BLINK);
   assign fire  = (opcode_type'(opcode) == OP_TICK) && timed && (count_ff <= 1);
   assign half_period = cfg.blink_period >> 1;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      unique case (opcode_type'(opcode))
         OP_TICK: begin
            if (fire) begin
               unique case (mode_ff)
                  MODE_HOLD, MODE_WAKE: mode_in = MODE_BLINK;
                  MODE_COOLDOWN:        mode_in = MODE_IDLE;
                  MODE_BLINK: begin
                     if (blinks_ff == '0 && !pressed_ff) mode_in = MODE_OFF;
                  end
                  default:              mode_in = mode_ff;
               endcase
            end
         end
         OP_PRESS: begin
            if (mode_ff == MODE_IDLE || mode_ff == MODE_COOLDOWN) mode_in = MODE_HOLD;
         end
         OP_RELEASE: begin
            if (mode_ff == MODE_HOLD) mode_in = MODE_COOLDOWN;
            else if (mode_ff == MODE_WAKE) mode_in = MODE_OFF;
            else if (mode_ff == MODE_BLINK && blinks_ff == '0) mode_in = MODE_OFF;
         end
         OP_BOOT: begin
            mode_in = switch_level ? MODE_WAKE : MODE_OFF;
         end
         default: mode_in = mode_ff;
      endcase
   end

   // timer, blink count, LED and switch state
   always_comb begin
      count_in   = count_ff;
      blinks_in  = blinks_ff;
      phase_in   = phase_ff;
      pressed_in = pressed_ff;
      led_in     = led_ff;
      unique case (opcode_type'(opcode))
         OP_TICK: begin
            if (timed) begin
               if (count_ff > 1) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  count_in = '0;
                  unique case (mode_ff)
                     MODE_HOLD, MODE_WAKE: begin
                        blinks_in = cfg.blink_total;
                        phase_in  = 1'b0;
                        led_in    = 1'b0;
                        count_in  = half_period;
                     end
                     MODE_COOLDOWN: led_in = 1'b0;
                     MODE_BLINK: begin
                        if (blinks_ff == '0) begin
                           led_in = 1'b0;
                        end else if (!phase_ff) begin
                           led_in   = 1'b1;
                           phase_in = 1'b1;
                           count_in = half_period;
                        end else begin
                           led_in    = 1'b0;
                           phase_in  = 1'b0;
                           blinks_in = blinks_ff - 1'b1;
                           count_in  = half_period;
                        end
                     end
                     default: led_in = led_ff;
                  endcase
               end
            end
         end
         OP_PRESS: begin
            pressed_in = 1'b1;
            if (mode_ff == MODE_IDLE || mode_ff == MODE_COOLDOWN) begin
               led_in   = 1'b1;
               count_in = cfg.hold_time;
            end
         end
         OP_RELEASE: begin
            pressed_in = 1'b0;
            if (mode_ff == MODE_HOLD) begin
               count_in = cfg.led_timeout;
            end else if (mode_ff == MODE_WAKE ||
                         (mode_ff == MODE_BLINK && blinks_ff == '0)) begin
               led_in = 1'b0;
            end
         end
         OP_BOOT: begin
            if (switch_level) begin
               pressed_in = 1'b1;
               led_in     = 1'b1;
               count_in   = cfg.hold_time;
            end else begin
               led_in = 1'b0;
            end
         end
         default: led_in = led_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         count_ff   <= '0;
         blinks_ff  <= '0;
         phase_ff   <= 1'b0;
         pressed_ff <= 1'b0;
         led_ff     <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         blinks_ff  <= blinks_in;
         phase_ff   <= phase_in;
         pressed_ff <= pressed_in;
         led_ff     <= led_in;
      end
   end

   // result word reflects the state after this event
   always_comb begin
      result.led_level = led_in;
      result.power_off = (mode_in == MODE_OFF);
      result.mode_code = mode_in;
   end

endmodule

`default_nettype wire
